### sv/fdp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fdp_pkg: shared types and constants of the frame descriptor pool
// transfer payloads, status codes, register map and default sizes
// ---------------------------------------------------------------------------
package fdp_pkg;

  // fixed field widths
  localparam int SIZE_W  = 24;
  localparam int TAG_W   = 8;
  localparam int TIME_W  = 64;
  localparam int TAGS_W  = 1 + 2 * TAG_W;

  // defaults for the top level parameters
  localparam int MAX_SLOTS_DEF   = 256;
  localparam int OFFSET_BITS_DEF = 24;

  // slot count clamp and ring margin
  localparam int MIN_SLOTS   = 3;
  localparam int RING_MARGIN = 2;

  // configuration register map
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int BUF_BYTES_W  = 24;
  localparam int SLOT_CNT_W   = 9;
  localparam logic REG_BUFFER_BYTES = 1'b0;
  localparam logic REG_SLOT_COUNT   = 1'b1;
  localparam logic [BUF_BYTES_W-1:0] BUFFER_BYTES_RST = 24'd1048576;
  localparam logic [SLOT_CNT_W-1:0]  SLOT_COUNT_RST   = 9'd30;

  typedef enum logic [2:0] {
    ST_STORED  = 3'd0,
    ST_DROPPED = 3'd1,
    ST_READ    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_BAD     = 3'd4
  } status_e;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_READ  = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [SIZE_W-1:0]  frame_size;
    logic               key_frame_in;
    logic [TAG_W-1:0]   encoding_in;
    logic [TAG_W-1:0]   stream_kind_in;
    logic [TIME_W-1:0]  timestamp_in;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic [SIZE_W-1:0]  frame_offset;
    logic [SIZE_W-1:0]  size_out;
    logic               key_frame_out;
    logic [TAG_W-1:0]   encoding_out;
    logic [TAG_W-1:0]   stream_kind_out;
    logic [TIME_W-1:0]  timestamp_out;
  } out_t;

endpackage

### sv/frame_descriptor_pool.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frame_descriptor_pool: ring of video frame descriptors
// keeps frame descriptors for a linear payload buffer, hands out byte
// offsets on write transfers and returns the oldest descriptor on reads
// ---------------------------------------------------------------------------
// Each input transfer has an accept cycle and an execute cycle: in the accept
// cycle the descriptor memory is read at the current read slot, in the next
// cycle the item is decided, the descriptor memory is written when a frame is
// stored (new descriptor) or read out (cleared slot) and the result is loaded
// into the output register. The execute cycle repeats while a previous result
// still waits in a stalled output register. After reset a clearing pass writes
// zero to every descriptor slot, during which no input transfer is taken;
// configuration writes are taken at any time.
// ---------------------------------------------------------------------------
module frame_descriptor_pool #(
  parameter int MAX_SLOTS   = fdp_pkg::MAX_SLOTS_DEF,
  parameter int OFFSET_BITS = fdp_pkg::OFFSET_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // item input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  fdp_pkg::in_t                       in_data_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output fdp_pkg::out_t                      out_data_o,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fdp_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [fdp_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [fdp_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  import fdp_pkg::*;

  // slot pointers and counts hold 0..MAX_SLOTS, memory index 0..MAX_SLOTS-1
  localparam int SLOT_W   = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W    = $clog2(MAX_SLOTS);
  // descriptor layout: time | tags | size | offset
  localparam int SIZE_LSB = OFFSET_BITS;
  localparam int TAG_LSB  = SIZE_LSB + SIZE_W;
  localparam int TIME_LSB = TAG_LSB + TAGS_W;
  localparam int ENTRY_W  = TIME_LSB + TIME_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic [IDX_W-1:0] clr_q, clr_d;

  // configuration registers
  logic [BUF_BYTES_W-1:0] buf_bytes_q;
  logic [SLOT_CNT_W-1:0]  slot_count_q;

  // pool state
  logic [SLOT_W-1:0] read_slot_q, read_slot_d;
  logic [SLOT_W-1:0] write_slot_q, write_slot_d;
  logic [SLOT_W-1:0] frames_q, frames_d;
  logic [SIZE_W-1:0] bytes_q, bytes_d;
  logic [SIZE_W-1:0] wpos_q, wpos_d;

  // item under work and output register
  in_t  item_q, item_d;
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  // memory port signals
  logic               mem_rd_en;
  logic [IDX_W-1:0]   mem_rd_addr;
  logic [ENTRY_W-1:0] mem_rd_data;
  logic               mem_wr_en;
  logic [IDX_W-1:0]   mem_wr_addr;
  logic [ENTRY_W-1:0] mem_wr_data;

  // ---- configuration port ----
  logic cfg_we;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      REG_BUFFER_BYTES: prdata = CFG_DATA_W'(buf_bytes_q);
      REG_SLOT_COUNT:   prdata = CFG_DATA_W'(slot_count_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_bytes_q  <= BUFFER_BYTES_RST;
      slot_count_q <= SLOT_COUNT_RST;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_BUFFER_BYTES: buf_bytes_q  <= pwdata[BUF_BYTES_W-1:0];
        REG_SLOT_COUNT:   slot_count_q <= pwdata[SLOT_CNT_W-1:0];
        default:          ;
      endcase
    end
  end

  // ---- effective slot count, clamped to MIN_SLOTS..MAX_SLOTS ----
  logic [SLOT_W-1:0] n_eff;

  always_comb begin
    if (slot_count_q < SLOT_CNT_W'(MIN_SLOTS)) begin
      n_eff = SLOT_W'(MIN_SLOTS);
    end else if (32'(slot_count_q) > MAX_SLOTS) begin
      n_eff = SLOT_W'(MAX_SLOTS);
    end else begin
      n_eff = SLOT_W'(slot_count_q);
    end
  end

  // read and write slots after wrap
  logic [SLOT_W-1:0] rd_slot, wr_slot;
  logic              wr_wrap;

  assign rd_slot = (read_slot_q >= n_eff) ? '0 : read_slot_q;
  assign wr_wrap = (write_slot_q >= n_eff);
  assign wr_slot = wr_wrap ? '0 : write_slot_q;

  // ---- write decision ----
  logic [SIZE_W:0]   bytes_sum, wpos_sum, limit;
  logic              wr_drop;
  logic [SIZE_W-1:0] wr_pos;
  logic [31:0]       wr_pos_ext;

  assign limit     = {1'b0, buf_bytes_q};
  assign bytes_sum = {1'b0, bytes_q} + {1'b0, item_q.frame_size};
  assign wpos_sum  = {1'b0, wpos_q} + {1'b0, item_q.frame_size};
  assign wr_drop   = (item_q.frame_size == '0)
                  || (frames_q >= (n_eff - SLOT_W'(RING_MARGIN)))
                  || (bytes_sum > limit)
                  || (wpos_sum > limit);
  // the index wrap also restarts the buffer
  assign wr_pos     = wr_wrap ? '0 : wpos_q;
  assign wr_pos_ext = 32'(wr_pos);

  // ---- read decision from the registered descriptor ----
  logic [OFFSET_BITS-1:0] rd_off;
  logic [31:0]            rd_off_ext;
  logic [SIZE_W-1:0]      rd_size;
  logic [TAGS_W-1:0]      rd_tags;
  logic [TIME_W-1:0]      rd_time;
  logic                   pool_empty;

  assign rd_off     = mem_rd_data[OFFSET_BITS-1:0];
  assign rd_off_ext = 32'(rd_off);
  assign rd_size    = mem_rd_data[TAG_LSB-1:SIZE_LSB];
  assign rd_tags    = mem_rd_data[TIME_LSB-1:TAG_LSB];
  assign rd_time    = mem_rd_data[ENTRY_W-1:TIME_LSB];
  assign pool_empty = (bytes_q == '0) || (frames_q == '0);

  // ---- control ----
  logic in_take, out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  // output register can take a new result this cycle
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    read_slot_d  = read_slot_q;
    write_slot_d = write_slot_q;
    frames_d     = frames_q;
    bytes_d      = bytes_q;
    wpos_d       = wpos_q;
    item_d       = item_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;

    mem_rd_en   = 1'b0;
    mem_rd_addr = rd_slot[IDX_W-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = clr_q;
    mem_wr_data = '0;

    case (state_q)
      S_CLEAR: begin
        // zero one descriptor slot per cycle
        mem_wr_en = 1'b1;
        clr_d     = clr_q + 1'b1;
        if (clr_q == IDX_W'(MAX_SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_take) begin
          item_d    = in_data_i;
          mem_rd_en = 1'b1;
          state_d   = S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          out_d       = '0;
          case (item_q.mode)
            MODE_WRITE: begin
              if (wr_drop) begin
                out_d.status = ST_DROPPED;
              end else begin
                mem_wr_en          = 1'b1;
                mem_wr_addr        = wr_slot[IDX_W-1:0];
                mem_wr_data        = {item_q.timestamp_in, item_q.stream_kind_in,
                                      item_q.encoding_in, item_q.key_frame_in,
                                      item_q.frame_size,
                                      wr_pos_ext[OFFSET_BITS-1:0]};
                out_d.status       = ST_STORED;
                out_d.frame_offset = wr_pos;
                wpos_d             = wr_pos + item_q.frame_size;
                bytes_d            = bytes_q + item_q.frame_size;
                write_slot_d       = wr_slot + 1'b1;
                frames_d           = frames_q + 1'b1;
              end
            end

            MODE_READ: begin
              if (pool_empty) begin
                // empty pool restarts every pointer
                read_slot_d  = '0;
                write_slot_d = '0;
                frames_d     = '0;
                bytes_d      = '0;
                wpos_d       = '0;
                out_d.status = ST_EMPTY;
              end else if (rd_size == '0) begin
                // bad entry: skip it
                read_slot_d  = rd_slot + 1'b1;
                frames_d     = frames_q - 1'b1;
                out_d.status = ST_BAD;
              end else begin
                out_d.status          = ST_READ;
                out_d.frame_offset    = rd_off_ext[SIZE_W-1:0];
                out_d.size_out        = rd_size;
                out_d.key_frame_out   = rd_tags[0];
                out_d.encoding_out    = rd_tags[TAG_W:1];
                out_d.stream_kind_out = rd_tags[TAGS_W-1:TAG_W+1];
                out_d.timestamp_out   = rd_time;
                frames_d              = frames_q - 1'b1;
                bytes_d               = (bytes_q >= rd_size) ? bytes_q - rd_size : '0;
                read_slot_d           = rd_slot + 1'b1;
                // release the slot
                mem_wr_en             = 1'b1;
                mem_wr_addr           = rd_slot[IDX_W-1:0];
                mem_wr_data           = '0;
              end
            end

            default: ;
          endcase
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      read_slot_q  <= '0;
      write_slot_q <= '0;
      frames_q     <= '0;
      bytes_q      <= '0;
      wpos_q       <= '0;
      out_valid_q  <= 1'b0;
      item_q       <= '0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      read_slot_q  <= read_slot_d;
      write_slot_q <= write_slot_d;
      frames_q     <= frames_d;
      bytes_q      <= bytes_d;
      wpos_q       <= wpos_d;
      out_valid_q  <= out_valid_d;
      item_q       <= item_d;
      out_q        <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // descriptor store
  fdp_desc_mem #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (ENTRY_W)
  ) u_desc_mem (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

endmodule

### sv/fdp_desc_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fdp_desc_mem: descriptor store
// single port write, single port read, registered read data
// ---------------------------------------------------------------------------
module fdp_desc_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 129,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

### sv/fdp_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fdp_checker: port level checks of the frame descriptor pool
// watches both transfer channels, bound to the top level
// ---------------------------------------------------------------------------
module fdp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input fdp_pkg::out_t out_data_o
);

  import fdp_pkg::*;

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is at work");

  // a new result only after an item was at work
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an item at work");

  // zero size entries are skipped, never read out
  a_read_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_READ |-> out_data_o.size_out != '0)
    else $error("frame read with zero size");

endmodule

bind frame_descriptor_pool fdp_checker u_fdp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the frame descriptor pool
// drives write and read transfers with random gaps on both sides, predicts
// every result with a cycle-free model of the descriptor ring and checks
// each result field by field in arrival order
// ---------------------------------------------------------------------------
module tb_top;
  import fdp_pkg::*;

  // clock, reset and block ports
  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // traffic shaping, percent of cycles in which each side idles
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  // long receiver hold-off, counted down by the receiving process
  int unsigned hold_cycles  = 0;
  int unsigned mismatch_count = 0;

  // expected results, oldest first
  out_t pending_results[$];

  // predictor copy of the registers
  logic [BUF_BYTES_W-1:0] buf_bytes_cfg  = BUFFER_BYTES_RST;
  logic [SLOT_CNT_W-1:0]  slot_count_cfg = SLOT_COUNT_RST;

  // predictor copy of the ring pointers and counts
  logic [8:0]        rd_slot     = '0;
  logic [8:0]        wr_slot     = '0;
  logic [8:0]        frames_held = '0;
  logic [SIZE_W-1:0] bytes_held  = '0;
  logic [SIZE_W:0]   wr_pos      = '0;

  // predictor copy of the descriptor store
  logic [SIZE_W-1:0] slot_offset [MAX_SLOTS_DEF];
  logic [SIZE_W-1:0] slot_size   [MAX_SLOTS_DEF];
  logic              slot_key    [MAX_SLOTS_DEF];
  logic [TAG_W-1:0]  slot_enc    [MAX_SLOTS_DEF];
  logic [TAG_W-1:0]  slot_kind   [MAX_SLOTS_DEF];
  logic [TIME_W-1:0] slot_ts     [MAX_SLOTS_DEF];

  frame_descriptor_pool u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // ring predictor
  // ---------------------------------------------------------------------------

  // slot count register clamped into the usable range
  function automatic int unsigned active_slots();
    if (slot_count_cfg < MIN_SLOTS) return MIN_SLOTS;
    if (slot_count_cfg > MAX_SLOTS_DEF) return MAX_SLOTS_DEF;
    return slot_count_cfg;
  endfunction

  // applies one accepted transfer to the ring copy and returns its result
  function automatic out_t pool_outcome(in_t item);
    out_t        res;
    int unsigned n;
    logic [7:0]  idx;
    logic [SIZE_W-1:0] sz;
    res = '0;
    n   = active_slots();
    if (item.mode == MODE_WRITE) begin
      sz = item.frame_size;
      // zero size, full ring or no room; room is checked before any wrap
      if (sz == 0 || frames_held >= n - RING_MARGIN ||
          32'(bytes_held) + 32'(sz) > 32'(buf_bytes_cfg) ||
          32'(wr_pos) + 32'(sz) > 32'(buf_bytes_cfg)) begin
        res.status = ST_DROPPED;
        return res;
      end
      if (wr_slot >= n) begin
        wr_slot = '0;
        wr_pos  = '0;
      end
      idx = wr_slot[7:0];
      slot_offset[idx] = wr_pos[SIZE_W-1:0];
      slot_size[idx]   = sz;
      slot_key[idx]    = item.key_frame_in;
      slot_enc[idx]    = item.encoding_in;
      slot_kind[idx]   = item.stream_kind_in;
      slot_ts[idx]     = item.timestamp_in;
      res.status       = ST_STORED;
      res.frame_offset = wr_pos[SIZE_W-1:0];
      wr_pos      = wr_pos + sz;
      bytes_held  = bytes_held + sz;
      wr_slot     = wr_slot + 1;
      frames_held = frames_held + 1;
      return res;
    end
    // empty pool clears every pointer
    if (bytes_held == 0 || frames_held == 0) begin
      rd_slot     = '0;
      wr_slot     = '0;
      frames_held = '0;
      bytes_held  = '0;
      wr_pos      = '0;
      res.status  = ST_EMPTY;
      return res;
    end
    if (rd_slot >= n) rd_slot = '0;
    idx = rd_slot[7:0];
    // slot without a descriptor is skipped
    if (slot_size[idx] == 0) begin
      rd_slot     = rd_slot + 1;
      frames_held = frames_held - 1;
      res.status  = ST_BAD;
      return res;
    end
    res.status          = ST_READ;
    res.frame_offset    = slot_offset[idx];
    res.size_out        = slot_size[idx];
    res.key_frame_out   = slot_key[idx];
    res.encoding_out    = slot_enc[idx];
    res.stream_kind_out = slot_kind[idx];
    res.timestamp_out   = slot_ts[idx];
    frames_held = frames_held - 1;
    // byte count saturates at zero
    if (bytes_held >= slot_size[idx]) bytes_held = bytes_held - slot_size[idx];
    else bytes_held = '0;
    slot_offset[idx] = '0;
    slot_size[idx]   = '0;
    slot_key[idx]    = 1'b0;
    slot_enc[idx]    = '0;
    slot_kind[idx]   = '0;
    slot_ts[idx]     = '0;
    rd_slot = rd_slot + 1;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic check_result(input out_t got);
    out_t want;
    if (pending_results.size() == 0) begin
      $display("%0t ns: unexpected result expected none actual %p", $time, got);
      mismatch_count++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("status", 64'(want.status), 64'(got.status));
    compare_field("frame_offset", 64'(want.frame_offset), 64'(got.frame_offset));
    compare_field("size_out", 64'(want.size_out), 64'(got.size_out));
    compare_field("key_frame_out", 64'(want.key_frame_out), 64'(got.key_frame_out));
    compare_field("encoding_out", 64'(want.encoding_out), 64'(got.encoding_out));
    compare_field("stream_kind_out", 64'(want.stream_kind_out),
                  64'(got.stream_kind_out));
    compare_field("timestamp_out", want.timestamp_out, got.timestamp_out);
  endtask

  // receiving side: checks every result transfer, then picks the next stall;
  // a pending hold-off keeps the stall up regardless of the gap rate
  always @(posedge clk) begin
    if (out_valid && !out_stall) check_result(out_data);
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_gap_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // sending side
  // ---------------------------------------------------------------------------

  // offers one item after a random gap and predicts it once it is taken;
  // valid is left high so back-to-back items need no extra edge
  task automatic send_frame(input in_t item);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(pool_outcome(item));
  endtask

  // lowers valid and waits until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // frame sizes scaled to the current buffer and slot count, with some
  // zero, full-range and near-buffer sizes mixed in
  function automatic logic [SIZE_W-1:0] random_size();
    int unsigned pick, lim, cap;
    pick = $urandom_range(99);
    lim  = buf_bytes_cfg;
    cap  = lim / active_slots();
    if (cap == 0) cap = 1;
    if (pick < 4) return '0;
    if (pick < 9) return SIZE_W'($urandom);
    if (pick < 20) return SIZE_W'($urandom_range(lim, lim / 2));
    return SIZE_W'($urandom_range(cap, 1));
  endfunction

  // every field is random, reads included, so that all input bits toggle
  function automatic in_t random_item(int unsigned write_pct);
    in_t item;
    item.mode           = ($urandom_range(99) < write_pct) ? MODE_WRITE : MODE_READ;
    item.frame_size     = random_size();
    item.key_frame_in   = 1'($urandom);
    item.encoding_in    = TAG_W'($urandom);
    item.stream_kind_in = TAG_W'($urandom);
    item.timestamp_in   = {$urandom, $urandom};
    return item;
  endfunction

  function automatic in_t write_item(logic [SIZE_W-1:0] sz);
    in_t item;
    item = random_item(100);
    item.frame_size = sz;
    return item;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------

  // each access ends by returning the port to idle so that back-to-back accesses
  // never drive the port twice in the same edge
  task automatic write_register(input logic reg_idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (reg_idx == REG_BUFFER_BYTES) buf_bytes_cfg = value[BUF_BYTES_W-1:0];
    else slot_count_cfg = value[SLOT_CNT_W-1:0];
    @(posedge clk);
  endtask

  task automatic read_register(input logic reg_idx, output logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // read back both registers and compare with the predictor copy
  task automatic check_registers();
    logic [CFG_DATA_W-1:0] value;
    read_register(REG_BUFFER_BYTES, value);
    compare_field("buffer_bytes", 64'(buf_bytes_cfg), 64'(value[BUF_BYTES_W-1:0]));
    read_register(REG_SLOT_COUNT, value);
    compare_field("slot_count", 64'(slot_count_cfg), 64'(value[SLOT_CNT_W-1:0]));
  endtask

  // new settings only once the block is idle; ring contents are kept
  task automatic set_pool_config(input int unsigned buf_bytes, input int unsigned slots);
    wait_drained();
    write_register(REG_BUFFER_BYTES, CFG_DATA_W'(buf_bytes));
    write_register(REG_SLOT_COUNT, CFG_DATA_W'(slots));
    check_registers();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_register_defaults();
    check_registers();
  endtask

  // short hand-built sequence over a 100 byte buffer
  task automatic test_edge_cases();
    in_t first, second;
    send_gap_pct = 37;
    recv_gap_pct = 51;
    set_pool_config(100, 6);
    send_frame(random_item(0));              // read of an empty pool
    send_frame(write_item('0));              // zero size is dropped
    first = write_item(24'd40);
    first.key_frame_in   = 1'b1;
    first.encoding_in    = '1;
    first.stream_kind_in = '0;
    first.timestamp_in   = '1;
    second = write_item(24'd60);
    second.key_frame_in   = 1'b0;
    second.encoding_in    = '0;
    second.stream_kind_in = '1;
    second.timestamp_in   = '0;
    send_frame(first);
    send_frame(second);                      // buffer exactly full
    send_frame(write_item(24'd1));           // byte total would overflow
    send_frame(random_item(0));
    send_frame(random_item(0));
    send_frame(write_item(24'd1));           // write position at the end
    send_frame(write_item('1));              // largest frame size
    send_frame(random_item(0));              // empty read resets pointers
    send_frame(write_item(24'd10));
    send_frame(write_item(24'd10));
    send_frame(write_item(24'd10));
    send_frame(write_item(24'd20));
    send_frame(write_item(24'd1));           // ring full
    // shrink the ring below its fill: read wrap lands on a cleared slot
    set_pool_config(100, 0);
    repeat (3) send_frame(random_item(0));
    send_frame(random_item(0));              // bad entry skipped
    send_frame(random_item(0));              // empty, stale slot left behind
    // single-frame ring walks the write index round to a wrap
    send_frame(write_item(24'd5));
    send_frame(random_item(0));
    send_frame(write_item(24'd5));
    send_frame(random_item(0));
    send_frame(write_item(24'd5));
    send_frame(random_item(0));
    send_frame(write_item(24'd90));          // no room at the position before wrap
    send_frame(write_item(24'd5));           // write wrap
    // grow past the clamp: read reaches the stale slot, bytes saturate
    set_pool_config(100, 511);
    send_frame(random_item(0));
    send_frame(random_item(0));
  endtask

  // phases of random traffic, settings changed while frames are still held
  task automatic test_random_traffic();
    int unsigned buf_bytes, slots, write_pct, count;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0:       begin buf_bytes = 4096;     slots = 8;   end
        1:       begin buf_bytes = 16777215; slots = 256; end
        2:       begin buf_bytes = 1;        slots = 3;   end
        3:       begin buf_bytes = 600;      slots = 4;   end
        4:       begin buf_bytes = 65536;    slots = 30;  end
        5:       begin buf_bytes = 2000;     slots = 511; end
        6:       begin buf_bytes = 0;        slots = 12;  end
        7:       begin buf_bytes = 300;      slots = 2;   end
        8:       begin buf_bytes = 1048576;  slots = 30;  end
        10:      begin
          buf_bytes = $urandom_range(16777215, 1);
          slots     = $urandom_range(511, 0);
        end
        default: begin
          buf_bytes = $urandom_range(5000, 1);
          slots     = $urandom_range(40, 0);
        end
      endcase
      // receiver-heavy gaps, then sender-heavy, then full speed
      if (phase < 4) begin
        send_gap_pct = 37;
        recv_gap_pct = 51;
      end else if (phase < 8) begin
        send_gap_pct = 51;
        recv_gap_pct = 37;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      set_pool_config(buf_bytes, slots);
      write_pct = $urandom_range(70, 40);
      count     = (phase == 6) ? 40 : 105;
      repeat (count) send_frame(random_item(write_pct));
    end
  endtask

  // receiver holds off for a long stretch while the sender keeps offering,
  // so the block backs up and stalls its input; then the sender pauses
  task automatic test_stall_pressure();
    set_pool_config(4096, 12);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_cycles  = 300;
    repeat (40) send_frame(random_item(50));
    wait_drained();
    repeat (20) send_frame(random_item(60));
  endtask

  initial begin
    for (int i = 0; i < MAX_SLOTS_DEF; i++) begin
      slot_offset[i] = '0;
      slot_size[i]   = '0;
      slot_key[i]    = 1'b0;
      slot_enc[i]    = '0;
      slot_kind[i]   = '0;
      slot_ts[i]     = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_defaults();
    test_edge_cases();
    test_random_traffic();
    test_stall_pressure();
    wait_drained();
    // catch any stray result after the last expected one
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
